[design/rspa_pkg.sv]
`default_nettype none

package rspa_pkg;

    localparam int STACK_ENTRIES = 64;
    localparam int PAGE_BYTES    = 4096;

    localparam int ADDR_W  = 52;
    localparam int LEN_W   = 53;
    localparam int TOT_W   = 58;
    localparam int DEPTH_W = $clog2(STACK_ENTRIES + 1);
    localparam int IDX_W   = $clog2(STACK_ENTRIES);

    localparam int S_DATA_W = ((ADDR_W + LEN_W + 1 + 7) / 8) * 8;
    localparam int M_DATA_W = ((ADDR_W + TOT_W + 7) / 8) * 8;

    localparam logic [1:0] KIND_ADD   = 2'd0;
    localparam logic [1:0] KIND_ALLOC = 2'd1;
    localparam logic [1:0] KIND_FREE  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [LEN_W-1:0]  PAGE_SIZE = LEN_W'(PAGE_BYTES);
    localparam logic [ADDR_W-1:0] PAGE_STEP = ADDR_W'(PAGE_BYTES);
    localparam logic [TOT_W-1:0]  TOTAL_MAX = {TOT_W{1'b1}};

    typedef struct packed {
        logic              push;
        logic              pop;
        logic              rewrite;
        logic [ADDR_W-1:0] base;
        logic [LEN_W-1:0]  size;
    } stack_cmd_t;

    typedef struct packed {
        logic              empty;
        logic              full;
        logic [ADDR_W-1:0] top_base;
        logic [LEN_W-1:0]  top_size;
    } stack_stat_t;

endpackage

`default_nettype wire

[design/rspa_stack.sv]
`default_nettype none

module rspa_stack
    import rspa_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire stack_cmd_t cmd,
    output stack_stat_t     stat
);

    // top entry and the one below it in registers, the rest in memory
    logic [ADDR_W+LEN_W-1:0] mem [STACK_ENTRIES];

    logic [DEPTH_W-1:0]      depth_reg, depth_next;
    logic [ADDR_W-1:0]       top_base_reg;
    logic [LEN_W-1:0]        top_size_reg;
    logic [ADDR_W+LEN_W-1:0] below_reg;
    logic [IDX_W-1:0]        wr_idx, rd_idx;

    assign wr_idx = depth_reg[IDX_W-1:0] - IDX_W'(1);
    assign rd_idx = depth_reg[IDX_W-1:0] - IDX_W'(3);

    always_comb begin
        depth_next = depth_reg;
        if (cmd.push) begin
            depth_next = depth_reg + DEPTH_W'(1);
        end else if (cmd.pop) begin
            depth_next = depth_reg - DEPTH_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg <= '0;
        end else begin
            depth_reg <= depth_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            if (depth_reg != '0) begin
                mem[wr_idx] <= {top_base_reg, top_size_reg};
            end
            below_reg <= {top_base_reg, top_size_reg};
        end else if (cmd.pop) begin
            below_reg <= mem[rd_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push || cmd.rewrite) begin
            top_base_reg <= cmd.base;
            top_size_reg <= cmd.size;
        end else if (cmd.pop) begin
            {top_base_reg, top_size_reg} <= below_reg;
        end
    end

    assign stat.empty    = (depth_reg == '0);
    assign stat.full     = (depth_reg == DEPTH_W'(STACK_ENTRIES));
    assign stat.top_base = top_base_reg;
    assign stat.top_size = top_size_reg;

endmodule

`default_nettype wire

[design/region_stack_page_allocator.sv]
`default_nettype none
// channel  dir  tdata (low bit up)                              tuser
// s_       in   region_base[51:0] region_length[104:52]
//               usable[105], zero fill to 112                   kind[1:0]
// m_       out  alloc_page[51:0] free_bytes[109:52],
//               zero fill to 112                                status[1:0]
//
// One word per cycle sustained while m_tready is high; m_tvalid follows the input and result registers.
// Input register, then stack top update and result register in one pass;
// the stack keeps its top two entries in flops, the rest in a 1R1W memory.
// Reset clears the depth count and the free total; memory contents are not reset.
// A stalled m_ side holds one word in the input register before s_tready drops.

module region_stack_page_allocator
    import rspa_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output      logic                s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,  // region_base, region_length, usable
    input  wire logic [1:0]          s_tuser,  // kind
    output      logic                m_tvalid,
    input  wire logic                m_tready,
    output      logic [M_DATA_W-1:0] m_tdata,  // alloc_page, free_bytes
    output      logic [1:0]          m_tuser   // status
);

    logic              in_valid_reg;
    logic [1:0]        kind_reg;
    logic [ADDR_W-1:0] base_reg;
    logic [LEN_W-1:0]  len_reg;
    logic              usable_reg;

    logic              out_valid_reg;
    logic [ADDR_W-1:0] page_reg, page_next;
    logic [1:0]        status_reg, status_next;
    logic [TOT_W-1:0]  total_reg, total_next;

    logic              advance;
    stack_cmd_t        cmd;
    stack_stat_t       stat;

    logic              do_add, do_sub;
    logic [LEN_W-1:0]  amount;
    logic [TOT_W:0]    sum;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            kind_reg   <= s_tuser;
            base_reg   <= s_tdata[ADDR_W-1:0];
            len_reg    <= s_tdata[ADDR_W+LEN_W-1:ADDR_W];
            usable_reg <= s_tdata[ADDR_W+LEN_W];
        end
    end

    always_comb begin
        cmd         = '0;
        page_next   = '0;
        status_next = ST_OK;
        do_add      = 1'b0;
        do_sub      = 1'b0;
        amount      = '0;
        unique case (kind_reg)
            KIND_ADD: begin
                if (usable_reg) begin
                    if (stat.full) begin
                        status_next = ST_FULL;
                    end else begin
                        cmd.push = 1'b1;
                        cmd.base = base_reg;
                        cmd.size = len_reg;
                        do_add   = 1'b1;
                        amount   = len_reg;
                    end
                end
            end
            KIND_ALLOC: begin
                if (stat.empty) begin
                    status_next = ST_EMPTY;
                end else begin
                    page_next = stat.top_base;
                    do_sub    = 1'b1;
                    if (stat.top_size > PAGE_SIZE) begin
                        cmd.rewrite = 1'b1;
                        cmd.base    = stat.top_base + PAGE_STEP;
                        cmd.size    = stat.top_size - PAGE_SIZE;
                        amount      = PAGE_SIZE;
                    end else begin
                        cmd.pop = 1'b1;
                        amount  = stat.top_size;
                    end
                end
            end
            KIND_FREE: begin
                if (stat.full) begin
                    status_next = ST_FULL;
                end else begin
                    cmd.push = 1'b1;
                    cmd.base = base_reg;
                    cmd.size = PAGE_SIZE;
                    do_add   = 1'b1;
                    amount   = PAGE_SIZE;
                end
            end
            default: begin
            end
        endcase
        if (!advance) begin
            cmd = '0;
        end
    end

    assign sum = {1'b0, total_reg} + (TOT_W+1)'(amount);

    always_comb begin
        total_next = total_reg;
        if (do_add) begin
            total_next = (sum >= {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[TOT_W-1:0];
        end else if (do_sub) begin
            total_next = (TOT_W'(amount) >= total_reg) ? '0 : total_reg - TOT_W'(amount);
        end
    end

    rspa_stack u_stack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .stat    (stat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
        end else begin
            if (advance) begin
                out_valid_reg <= 1'b1;
                total_reg     <= total_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            page_reg   <= page_next;
            status_reg <= status_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {{(M_DATA_W - ADDR_W - TOT_W){1'b0}}, total_reg, page_reg};

`ifndef SYNTH
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> stat.empty)
        else $error("stack not empty after reset");

    a_never_both: assert property (@(posedge aclk) disable iff (!aresetn)
        !(stat.empty && stat.full))
        else $error("stack empty and full at once");

    a_accept_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> in_valid_reg)
        else $error("accepted word lost from input register");

    a_empty_page_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == ST_EMPTY || m_tuser == ST_FULL)) |-> (page_reg == '0))
        else $error("failed operation returned a page");
`endif

endmodule

`default_nettype wire
